// ===== sv/tie_pkg.sv =====
// package: shared types, constants and codes for the interpreter execute unit
`default_nettype none
package tie_pkg;
    localparam int PROG_DEPTH = 256;
    localparam int VAR_DEPTH  = 64;
    localparam int INSTR_W    = 38;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_START  = 2'd2,
        OP_STEP   = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        C_MOV  = 4'd0,
        C_ADD  = 4'd1,
        C_SUB  = 4'd2,
        C_MUL  = 4'd3,
        C_DIV  = 4'd4,
        C_OUT  = 4'd5,
        C_IN   = 4'd6,
        C_JMP  = 4'd7,
        C_BEQZ = 4'd8,
        C_BNEZ = 4'd9,
        C_BGTZ = 4'd10,
        C_BLTZ = 4'd11
    } t_code;

    typedef enum logic [1:0] {
        F_NONE = 2'd0,
        F_DIV0 = 2'd1,
        F_VARS = 2'd2,
        F_PROG = 2'd3
    } t_fault;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FETCH,
        S_SRCH_A,
        S_SRCH_B,
        S_CHECK,
        S_READ_A,
        S_READ_B,
        S_EXEC,
        S_DIV,
        S_WRITE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic        start;
        logic [15:0] dividend;
        logic [15:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [15:0] quotient;
    } t_div_rsp;
endpackage
`default_nettype wire

// ===== sv/tiny_interpreter_execute_unit_top.sv =====
// top level of the interpreter execute unit
// channel | direction | handshake         | payload
// input   | in        | i_valid / o_stall | op, code, operands, flags, in_char
// output  | out       | o_valid / i_stall | next_index, halted, out chars, fault
// clear, append, start and a halted step go straight to the result state; a step
// runs fetch, a linear key scan over the key memory, check, both reads, execute,
// the divider for a nonzero divide, write and result; a full variable table ends
// a step at check; one item at a time; reset is synchronous active low and clears
// only state, counters, index and divider flags; a stalled result holds until taken
`default_nettype none
module tiny_interpreter_execute_unit_top #(
    parameter int PROG_DEPTH = tie_pkg::PROG_DEPTH,
    parameter int VAR_DEPTH  = tie_pkg::VAR_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_op,
    input  wire logic [3:0]  i_code,
    input  wire logic signed [15:0] i_first_operand,
    input  wire logic signed [15:0] i_second_operand,
    input  wire logic        i_first_is_var,
    input  wire logic        i_second_is_var,
    input  wire logic signed [8:0]  i_in_char,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic signed [15:0] o_next_index,
    output logic             o_halted,
    output logic             o_out_valid,
    output logic [7:0]       o_out_char,
    output logic             o_in_taken,
    output logic [1:0]       o_fault
);
    tie_ctrl #(.PROG_DEPTH(PROG_DEPTH), .VAR_DEPTH(VAR_DEPTH)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_op(i_op), .i_code(i_code),
        .i_first_operand(i_first_operand), .i_second_operand(i_second_operand),
        .i_first_is_var(i_first_is_var), .i_second_is_var(i_second_is_var),
        .i_in_char(i_in_char),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_next_index(o_next_index), .o_halted(o_halted),
        .o_out_valid(o_out_valid), .o_out_char(o_out_char),
        .o_in_taken(o_in_taken), .o_fault(o_fault)
    );
endmodule
`default_nettype wire

// ===== sv/tie_ram.sv =====
// generic single-port ram with registered read
`default_nettype none
module tie_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// ===== sv/tie_div.sv =====
// iterative 16-bit signed divider, truncating toward zero, one bit per cycle
`default_nettype none
module tie_div (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire tie_pkg::t_div_req i_req,
    output tie_pkg::t_div_rsp     o_rsp
);
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [4:0]  r_cnt, n_cnt;
    logic [15:0] r_rem, n_rem;
    logic [15:0] r_quo, n_quo;
    logic [15:0] r_dsr, n_dsr;
    logic        r_neg, n_neg;
    logic [16:0] w_trial;
    logic [15:0] w_shift;

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_dsr   = r_dsr;
        n_neg   = r_neg;
        w_shift = {r_rem[14:0], r_quo[15]};
        w_trial = {1'b0, w_shift} - {1'b0, r_dsr};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = 5'd0;
            n_rem  = 16'd0;
            n_quo  = i_req.dividend[15] ? 16'(-i_req.dividend) : i_req.dividend;
            n_dsr  = i_req.divisor[15] ? 16'(-i_req.divisor) : i_req.divisor;
            n_neg  = i_req.dividend[15] ^ i_req.divisor[15];
        end else if (r_busy) begin
            if (r_rem[15] || !w_trial[16]) begin
                n_rem = r_rem[15] ? 16'(w_shift - r_dsr) : w_trial[15:0];
                n_quo = {r_quo[14:0], 1'b1};
            end else begin
                n_rem = w_shift;
                n_quo = {r_quo[14:0], 1'b0};
            end
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd15) begin
                n_busy = 1'b0;
                n_done = 1'b1;
                if (r_neg) begin
                    n_quo = 16'(-{n_quo});
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dsr <= n_dsr;
        r_neg <= n_neg;
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

    a_done_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("divider done while busy");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |=> r_busy) else $error("divider not busy after start");
    a_done_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("divider done held");
endmodule
`default_nettype wire

// ===== sv/tie_ctrl.sv =====
// sequencer: program and variable memories read, modified and written back
`default_nettype none
module tie_ctrl #(
    parameter int PROG_DEPTH = tie_pkg::PROG_DEPTH,
    parameter int VAR_DEPTH  = tie_pkg::VAR_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_op,
    input  wire logic [3:0]  i_code,
    input  wire logic [15:0] i_first_operand,
    input  wire logic [15:0] i_second_operand,
    input  wire logic        i_first_is_var,
    input  wire logic        i_second_is_var,
    input  wire logic [8:0]  i_in_char,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [15:0]      o_next_index,
    output logic             o_halted,
    output logic             o_out_valid,
    output logic [7:0]       o_out_char,
    output logic             o_in_taken,
    output logic [1:0]       o_fault
);
    localparam int PAW = $clog2(PROG_DEPTH);
    localparam int VAW = $clog2(VAR_DEPTH);
    localparam int PLW = $clog2(PROG_DEPTH + 1);
    localparam int VCW = $clog2(VAR_DEPTH + 1);

    tie_pkg::t_state r_state, n_state;

    logic [PLW-1:0] r_plen, n_plen;
    logic [15:0]    r_idx, n_idx;
    logic [VCW-1:0] r_vcnt, n_vcnt;

    logic [8:0]  r_inch;
    logic [3:0]  r_code;
    logic [15:0] r_opa, r_opb;
    logic        r_va, r_vb;
    logic [VCW-1:0] r_scan;
    logic        r_fa, r_fb;
    logic [VAW-1:0] r_sa, r_sb;
    logic [15:0] r_a, r_b;
    logic [15:0] r_res;
    logic        r_wr;
    logic [15:0] r_next;
    logic        r_ov, r_it;
    logic [7:0]  r_oc;
    logic [1:0]  r_flt;

    logic        p_we;
    logic [PAW-1:0] p_addr;
    logic [tie_pkg::INSTR_W-1:0] p_wdata, p_rdata;
    logic        k_we;
    logic [VAW-1:0] k_addr;
    logic [15:0] k_wdata, k_rdata;
    logic        v_we;
    logic [VAW-1:0] v_addr;
    logic [15:0] v_wdata, v_rdata;

    tie_pkg::t_div_req w_dreq;
    tie_pkg::t_div_rsp w_drsp;

    logic        w_acc, w_halt_now, w_need_b;
    logic [VCW:0] w_need;
    logic [31:0] w_prod;
    logic [15:0] w_res, w_next;
    logic        w_wr, w_ov, w_it, w_div0;

    tie_ram #(.WIDTH(tie_pkg::INSTR_W), .DEPTH(PROG_DEPTH)) u_prog (
        .i_clk(i_clk), .i_we(p_we), .i_addr(p_addr), .i_wdata(p_wdata), .o_rdata(p_rdata));
    tie_ram #(.WIDTH(16), .DEPTH(VAR_DEPTH)) u_keys (
        .i_clk(i_clk), .i_we(k_we), .i_addr(k_addr), .i_wdata(k_wdata), .o_rdata(k_rdata));
    tie_ram #(.WIDTH(16), .DEPTH(VAR_DEPTH)) u_vals (
        .i_clk(i_clk), .i_we(v_we), .i_addr(v_addr), .i_wdata(v_wdata), .o_rdata(v_rdata));
    tie_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_dreq), .o_rsp(w_drsp));

    assign w_acc      = i_valid && !o_stall;
    assign o_stall    = (r_state != tie_pkg::S_IDLE);
    assign w_halt_now = r_idx[15] || ({{(16-PLW){1'b0}}, r_plen} <= r_idx) ||
                        (PLW > 16);
    assign w_need_b   = r_vb && !r_fb && !(r_va && !r_fa && r_opa == r_opb);
    assign w_need     = (VCW+1)'(r_vcnt) + (VCW+1)'(r_va && !r_fa) + (VCW+1)'(w_need_b);
    assign w_prod     = {16'd0, r_a} * {16'd0, r_b};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tie_pkg::S_IDLE:
                if (w_acc && tie_pkg::t_op'(i_op) == tie_pkg::OP_STEP && !w_halt_now)
                    n_state = tie_pkg::S_FETCH;
                else if (w_acc)
                    n_state = tie_pkg::S_DONE;
            tie_pkg::S_FETCH: n_state = tie_pkg::S_SRCH_A;
            tie_pkg::S_SRCH_A, tie_pkg::S_SRCH_B:
                if (r_scan >= r_vcnt) n_state = tie_pkg::S_CHECK;
            tie_pkg::S_CHECK:
                if (w_need > (VCW+1)'(VAR_DEPTH)) n_state = tie_pkg::S_DONE;
                else n_state = tie_pkg::S_READ_A;
            tie_pkg::S_READ_A: n_state = tie_pkg::S_READ_B;
            tie_pkg::S_READ_B: n_state = tie_pkg::S_EXEC;
            tie_pkg::S_EXEC:
                if (tie_pkg::t_code'(r_code) == tie_pkg::C_DIV && r_b != 16'd0)
                    n_state = tie_pkg::S_DIV;
                else n_state = tie_pkg::S_WRITE;
            tie_pkg::S_DIV: if (w_drsp.done) n_state = tie_pkg::S_WRITE;
            tie_pkg::S_WRITE: n_state = tie_pkg::S_DONE;
            tie_pkg::S_DONE: if (!i_stall) n_state = tie_pkg::S_IDLE;
            default: n_state = tie_pkg::S_IDLE;
        endcase
    end

    // memory ports
    always_comb begin
        p_we    = 1'b0;
        p_addr  = r_idx[PAW-1:0];
        p_wdata = {r_code, r_opa, r_opb, r_va, r_vb};
        k_we    = 1'b0;
        k_addr  = r_scan[VAW-1:0];
        k_wdata = r_opa;
        v_we    = 1'b0;
        v_addr  = r_sa;
        v_wdata = 16'd0;
        w_dreq.start    = 1'b0;
        w_dreq.dividend = r_a;
        w_dreq.divisor  = r_b;
        case (r_state)
            tie_pkg::S_IDLE: begin
                p_addr  = r_plen[PAW-1:0];
                p_wdata = {i_code, i_first_operand, i_second_operand,
                           i_first_is_var, i_second_is_var};
                p_we    = w_acc && tie_pkg::t_op'(i_op) == tie_pkg::OP_APPEND &&
                          r_plen < PLW'(PROG_DEPTH);
            end
            tie_pkg::S_CHECK: begin
                // create a new first key, else read the first value
                if (w_need <= (VCW+1)'(VAR_DEPTH) && r_va && !r_fa) begin
                    k_we = 1'b1; k_addr = r_vcnt[VAW-1:0]; k_wdata = r_opa;
                    v_we = 1'b1; v_addr = r_vcnt[VAW-1:0];
                end
            end
            tie_pkg::S_READ_A: begin
                // create a new second key, else read the second value
                v_addr = r_sb;
                if (r_vb && !r_fb && !(r_va && r_opa == r_opb)) begin
                    k_we = 1'b1; k_addr = r_sb; k_wdata = r_opb;
                    v_we = 1'b1;
                end
            end
            tie_pkg::S_EXEC: begin
                w_dreq.start = tie_pkg::t_code'(r_code) == tie_pkg::C_DIV && r_b != 16'd0;
            end
            tie_pkg::S_WRITE: begin
                if (r_wr) begin
                    if (r_va) begin
                        v_we = 1'b1; v_addr = r_sa; v_wdata = r_res;
                    end else begin
                        p_we    = 1'b1;
                        p_wdata = {r_code, r_res, r_opb, r_va, r_vb};
                    end
                end
            end
            default: ;
        endcase
    end

    // operation on settled operands
    always_comb begin
        w_res  = r_a;
        w_wr   = 1'b0;
        w_next = r_idx + 16'd1;
        w_ov   = 1'b0;
        w_it   = 1'b0;
        w_div0 = 1'b0;
        case (tie_pkg::t_code'(r_code))
            tie_pkg::C_MOV: begin w_res = r_b; w_wr = 1'b1; end
            tie_pkg::C_ADD: begin w_res = r_a + r_b; w_wr = 1'b1; end
            tie_pkg::C_SUB: begin w_res = r_a - r_b; w_wr = 1'b1; end
            tie_pkg::C_MUL: begin w_res = w_prod[15:0]; w_wr = 1'b1; end
            tie_pkg::C_DIV: w_div0 = (r_b == 16'd0);
            tie_pkg::C_OUT: w_ov = 1'b1;
            tie_pkg::C_IN: begin
                w_res = {{7{r_inch[8]}}, r_inch}; w_wr = 1'b1; w_it = 1'b1;
            end
            tie_pkg::C_JMP: w_next = r_a;
            tie_pkg::C_BEQZ: if (r_a == 16'd0) w_next = r_idx + r_b;
            tie_pkg::C_BNEZ: if (r_a != 16'd0) w_next = r_idx + r_b;
            tie_pkg::C_BGTZ: if (!r_a[15] && r_a != 16'd0) w_next = r_idx + r_b;
            tie_pkg::C_BLTZ: if (r_a[15]) w_next = r_idx + r_b;
            default: ;
        endcase
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            tie_pkg::S_IDLE: begin
                r_inch <= i_in_char;
                r_scan <= '0;
                r_fa   <= 1'b0;
                r_fb   <= 1'b0;
                r_ov   <= 1'b0;
                r_oc   <= 8'd0;
                r_it   <= 1'b0;
                r_wr   <= 1'b0;
                r_flt  <= (w_acc && tie_pkg::t_op'(i_op) == tie_pkg::OP_APPEND &&
                           r_plen >= PLW'(PROG_DEPTH)) ? tie_pkg::F_PROG : tie_pkg::F_NONE;
            end
            tie_pkg::S_FETCH: r_scan <= r_scan + VCW'(1);
            tie_pkg::S_SRCH_A: begin
                if (r_scan == VCW'(1)) begin
                    {r_code, r_opa, r_opb, r_va, r_vb} <= p_rdata;
                end
                // key read for r_scan-1 arrives now
                if (r_scan - VCW'(1) < r_vcnt) begin
                    if ((r_scan == VCW'(1) ? p_rdata[33:18] : r_opa) == k_rdata &&
                        !r_fa) begin
                        r_fa <= 1'b1; r_sa <= VAW'(r_scan - VCW'(1));
                    end
                    if ((r_scan == VCW'(1) ? p_rdata[17:2] : r_opb) == k_rdata &&
                        !r_fb) begin
                        r_fb <= 1'b1; r_sb <= VAW'(r_scan - VCW'(1));
                    end
                end
                r_scan <= r_scan + VCW'(1);
            end
            tie_pkg::S_CHECK: begin
                if (r_va && !r_fa) r_sa <= r_vcnt[VAW-1:0];
                if (r_vb && !r_fb) begin
                    if (r_va && !r_fa && r_opa == r_opb) r_sb <= r_vcnt[VAW-1:0];
                    else r_sb <= VAW'(r_vcnt + VCW'(r_va && !r_fa));
                end
                if (w_need > (VCW+1)'(VAR_DEPTH)) r_flt <= tie_pkg::F_VARS;
            end
            // a newly created variable reads as zero
            tie_pkg::S_READ_A: r_a <= r_va ? (r_fa ? v_rdata : 16'd0) : r_opa;
            tie_pkg::S_READ_B: r_b <= r_vb ? (r_fb ? v_rdata : 16'd0) : r_opb;
            tie_pkg::S_EXEC: begin
                r_next <= w_next;
                r_res  <= w_res;
                r_wr   <= w_wr;
                r_ov   <= w_ov;
                r_oc   <= w_ov ? r_a[7:0] : 8'd0;
                r_it   <= w_it;
                if (w_div0) r_flt <= tie_pkg::F_DIV0;
            end
            tie_pkg::S_DIV: begin
                if (w_drsp.done) begin
                    r_res <= w_drsp.quotient;
                    r_wr  <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    // control state
    always_comb begin
        n_plen = r_plen;
        n_idx  = r_idx;
        n_vcnt = r_vcnt;
        if (r_state == tie_pkg::S_IDLE && w_acc) begin
            case (tie_pkg::t_op'(i_op))
                tie_pkg::OP_CLEAR:  n_plen = '0;
                tie_pkg::OP_APPEND: if (r_plen < PLW'(PROG_DEPTH)) n_plen = r_plen + PLW'(1);
                tie_pkg::OP_START:  n_idx = 16'd0;
                default: ;
            endcase
        end
        if (r_state == tie_pkg::S_CHECK && w_need <= (VCW+1)'(VAR_DEPTH))
            n_vcnt = VCW'(w_need);
        if (r_state == tie_pkg::S_WRITE) n_idx = r_next;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tie_pkg::S_IDLE;
            r_plen  <= '0;
            r_idx   <= 16'd0;
            r_vcnt  <= '0;
        end else begin
            r_state <= n_state;
            r_plen  <= n_plen;
            r_idx   <= n_idx;
            r_vcnt  <= n_vcnt;
        end
    end

    // outputs
    always_comb begin
        o_valid      = (r_state == tie_pkg::S_DONE);
        o_next_index = r_idx;
        o_halted     = w_halt_now;
        o_out_valid  = r_ov;
        o_out_char   = r_oc;
        o_in_taken   = r_it;
        o_fault      = r_flt;
    end

    a_vcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vcnt <= VCW'(VAR_DEPTH)) else $error("variable count overflow");
    a_plen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_plen <= PLW'(PROG_DEPTH)) else $error("program length overflow");
    a_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tie_pkg::S_DIV) |-> (w_drsp.busy || w_drsp.done))
        else $error("divide state without divider");
endmodule
`default_nettype wire

// ===== sim/tiny_interpreter_execute_unit_top_tb.sv =====
// testbench for the interpreter execute unit: directed table then random programs vs predictor
`default_nettype none
module tiny_interpreter_execute_unit_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [3:0] C_UNUSED   = 4'd15;
    localparam int         CYCLE_LIMIT = 2000000;
    localparam int         ITEMS       = 1500;

    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  code;
        logic [15:0] a;
        logic [15:0] b;
        logic        va;
        logic        vb;
        logic [8:0]  ch;
    } t_cmd;

    typedef struct packed {
        logic [15:0] nidx;
        logic        halted;
        logic        ov;
        logic [7:0]  oc;
        logic        taken;
        logic [1:0]  fault;
    } t_res;

    typedef struct packed {
        t_cmd c;
        logic typed;
        t_res r;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [1:0] i_op = '0;
    logic [3:0] i_code = '0;
    logic signed [15:0] i_first_operand = '0;
    logic signed [15:0] i_second_operand = '0;
    logic i_first_is_var = 1'b0;
    logic i_second_is_var = 1'b0;
    logic signed [8:0] i_in_char = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic signed [15:0] o_next_index;
    logic o_halted;
    logic o_out_valid;
    logic [7:0] o_out_char;
    logic o_in_taken;
    logic [1:0] o_fault;

    logic tx_typed = 1'b0;
    t_res tx_exp = '0;

    tiny_interpreter_execute_unit_top i_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [3:0]  prog_code [tie_pkg::PROG_DEPTH];
    logic [15:0] prog_a [tie_pkg::PROG_DEPTH];
    logic [15:0] prog_b [tie_pkg::PROG_DEPTH];
    logic        prog_va [tie_pkg::PROG_DEPTH];
    logic        prog_vb [tie_pkg::PROG_DEPTH];
    int          prog_len = 0;
    logic [15:0] pc = '0;
    logic [15:0] var_key [tie_pkg::VAR_DEPTH];
    logic [15:0] var_val [tie_pkg::VAR_DEPTH];
    int          var_cnt = 0;

    t_res expected_results[$];
    int errors = 0;
    int sent = 0;
    int cycles = 0;
    int tx_idle = 0;
    int rx_pct = 0;
    bit rx_hold = 1'b0;

    function automatic bit off_end(logic [15:0] i);
        return $signed(i) < 0 || int'($signed(i)) >= prog_len;
    endfunction

    function automatic int find_var(logic [15:0] k);
        for (int i = 0; i < var_cnt; i++)
            if (var_key[i] == k) return i;
        return -1;
    endfunction

    function automatic int get_var(logic [15:0] k);
        int f;
        f = find_var(k);
        if (f >= 0) return f;
        var_key[var_cnt] = k;
        var_val[var_cnt] = '0;
        var_cnt++;
        return var_cnt - 1;
    endfunction

    function automatic t_res execute_item(t_cmd c);
        t_res r;
        int slot, need, ia, ib, q;
        bit na, nb, wr;
        logic [15:0] x, y, res, nxt;
        r = '0;
        case (c.op)
            tie_pkg::OP_CLEAR: prog_len = 0;
            tie_pkg::OP_APPEND: begin
                if (prog_len >= tie_pkg::PROG_DEPTH) begin
                    r.fault = tie_pkg::F_PROG;
                end else begin
                    prog_code[prog_len] = c.code;
                    prog_a[prog_len] = c.a;
                    prog_b[prog_len] = c.b;
                    prog_va[prog_len] = c.va;
                    prog_vb[prog_len] = c.vb;
                    prog_len++;
                end
            end
            tie_pkg::OP_START: pc = '0;
            default: begin
                if (!off_end(pc)) begin
                    slot = int'(pc);
                    na = prog_va[slot] && find_var(prog_a[slot]) < 0;
                    nb = prog_vb[slot] && find_var(prog_b[slot]) < 0;
                    need = int'(na) + int'(nb && !(na && prog_a[slot] == prog_b[slot]));
                    if (var_cnt + need > tie_pkg::VAR_DEPTH) begin
                        r.fault = tie_pkg::F_VARS;
                    end else begin
                        ia = prog_va[slot] ? get_var(prog_a[slot]) : -1;
                        ib = prog_vb[slot] ? get_var(prog_b[slot]) : -1;
                        x = (ia >= 0) ? var_val[ia] : prog_a[slot];
                        y = (ib >= 0) ? var_val[ib] : prog_b[slot];
                        res = x;
                        wr = 1'b0;
                        nxt = pc + 16'd1;
                        case (prog_code[slot])
                            tie_pkg::C_MOV: begin res = y; wr = 1'b1; end
                            tie_pkg::C_ADD: begin res = x + y; wr = 1'b1; end
                            tie_pkg::C_SUB: begin res = x - y; wr = 1'b1; end
                            tie_pkg::C_MUL: begin res = x * y; wr = 1'b1; end
                            tie_pkg::C_DIV: begin
                                if (y == '0) begin
                                    r.fault = tie_pkg::F_DIV0;
                                end else begin
                                    q = int'($signed(x)) / int'($signed(y));
                                    res = q[15:0];
                                    wr = 1'b1;
                                end
                            end
                            tie_pkg::C_OUT: begin r.ov = 1'b1; r.oc = x[7:0]; end
                            tie_pkg::C_IN: begin
                                res = {{7{c.ch[8]}}, c.ch};
                                wr = 1'b1;
                                r.taken = 1'b1;
                            end
                            tie_pkg::C_JMP: nxt = x;
                            tie_pkg::C_BEQZ: if (x == '0) nxt = pc + y;
                            tie_pkg::C_BNEZ: if (x != '0) nxt = pc + y;
                            tie_pkg::C_BGTZ: if ($signed(x) > 0) nxt = pc + y;
                            tie_pkg::C_BLTZ: if (x[15]) nxt = pc + y;
                            default: ;
                        endcase
                        if (wr) begin
                            if (ia >= 0) var_val[ia] = res;
                            else prog_a[slot] = res;
                        end
                        pc = nxt;
                    end
                end
            end
        endcase
        r.nidx = pc;
        r.halted = off_end(pc);
        return r;
    endfunction

    task automatic flag(string msg);
        errors++;
        if (errors <= 10) $display("%t mismatch: %s", $realtime, msg);
    endtask

    always @(posedge i_clk) begin
        t_cmd c;
        t_res p;
        if (i_rst_n && i_valid && !o_stall) begin
            c = {i_op, i_code, i_first_operand, i_second_operand,
                 i_first_is_var, i_second_is_var, i_in_char};
            p = execute_item(c);
            expected_results.push_back(tx_typed ? tx_exp : p);
        end
    end

    always @(posedge i_clk) begin
        t_res e, g;
        if (i_rst_n && o_valid && !i_stall) begin
            g = {o_next_index, o_halted, o_out_valid, o_out_char, o_in_taken, o_fault};
            if (expected_results.size() == 0) begin
                flag($sformatf("unexpected result %h", g));
            end else begin
                e = expected_results.pop_front();
                if (g.nidx != e.nidx)
                    flag($sformatf("next_index exp %0d got %0d", $signed(e.nidx),
                                   $signed(g.nidx)));
                if (g.halted != e.halted)
                    flag($sformatf("halted exp %0b got %0b", e.halted, g.halted));
                if (g.ov != e.ov)
                    flag($sformatf("out_valid exp %0b got %0b", e.ov, g.ov));
                if (g.oc != e.oc)
                    flag($sformatf("out_char exp %h got %h", e.oc, g.oc));
                if (g.taken != e.taken)
                    flag($sformatf("in_taken exp %0b got %0b", e.taken, g.taken));
                if (g.fault != e.fault)
                    flag($sformatf("fault exp %0d got %0d", e.fault, g.fault));
            end
        end
    end

    always @(posedge i_clk) begin
        if (rx_hold) i_stall <= 1'b1;
        else i_stall <= ($urandom_range(0, 99) < rx_pct);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL tiny_interpreter_execute_unit_top");
            $finish;
        end
    end

    // long receiver hold while the sender keeps offering items
    initial begin
        wait (sent > 200);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (400) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    task automatic send(t_cmd c, logic typed, t_res r);
        while ($urandom_range(0, 99) < tx_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        {i_op, i_code, i_first_operand, i_second_operand,
         i_first_is_var, i_second_is_var, i_in_char} <= c;
        tx_typed <= typed;
        tx_exp <= r;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sent++;
    endtask

    function automatic logic [15:0] pick_key();
        return ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15));
    endfunction

    function automatic logic [8:0] pick_char();
        return 9'($urandom_range(0, 256) - 1);
    endfunction

    function automatic t_cmd pick_instr(int n);
        t_cmd c;
        c.op = tie_pkg::OP_APPEND;
        c.code = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(12, 15))
                                              : 4'($urandom_range(0, 11));
        c.va = $urandom_range(0, 2) != 0;
        c.vb = 1'($urandom_range(0, 1));
        c.a = c.va ? pick_key() : ($urandom_range(0, 1) ? 16'($urandom)
                                                        : 16'($urandom_range(0, 16) - 8));
        c.b = c.vb ? pick_key() : ($urandom_range(0, 1) ? 16'($urandom)
                                                        : 16'($urandom_range(0, 8) - 4));
        if (c.code == tie_pkg::C_JMP && !c.va) c.a = 16'($urandom_range(0, n));
        if (c.code >= tie_pkg::C_BEQZ && c.code <= tie_pkg::C_BLTZ && !c.vb)
            c.b = 16'($urandom_range(0, 6) - 3);
        c.ch = pick_char();
        return c;
    endfunction

    t_row dir_rows[] = '{
        '{'{tie_pkg::OP_STEP, tie_pkg::C_MOV, 16'h0000, 16'h0000, 1'b0, 1'b0, 9'h000},
          1'b1, '{16'd0, 1'b1, 1'b0, 8'h00, 1'b0, tie_pkg::F_NONE}},
        '{'{tie_pkg::OP_APPEND, tie_pkg::C_DIV, 16'h8000, 16'hffff, 1'b0, 1'b0, 9'h000},
          1'b0, '0},
        '{'{tie_pkg::OP_APPEND, tie_pkg::C_DIV, 16'h0001, 16'h0000, 1'b1, 1'b0, 9'h000},
          1'b0, '0},
        '{'{tie_pkg::OP_APPEND, tie_pkg::C_OUT, 16'h01ff, 16'h0000, 1'b0, 1'b0, 9'h000},
          1'b0, '0},
        '{'{tie_pkg::OP_APPEND, tie_pkg::C_IN, 16'h8000, 16'h0000, 1'b1, 1'b0, 9'h000},
          1'b0, '0},
        '{'{tie_pkg::OP_APPEND, tie_pkg::C_ADD, 16'h8000, 16'h7fff, 1'b1, 1'b0, 9'h000},
          1'b0, '0},
        '{'{tie_pkg::OP_APPEND, tie_pkg::C_MUL, 16'h8000, 16'h8000, 1'b1, 1'b1, 9'h000},
          1'b0, '0},
        '{'{tie_pkg::OP_APPEND, tie_pkg::C_SUB, 16'h0005, 16'h8000, 1'b1, 1'b0, 9'h000},
          1'b0, '0},
        '{'{tie_pkg::OP_APPEND, tie_pkg::C_BLTZ, 16'h8000, 16'h0001, 1'b1, 1'b0, 9'h000},
          1'b0, '0},
        '{'{tie_pkg::OP_APPEND, tie_pkg::C_BGTZ, 16'h0005, 16'h0001, 1'b1, 1'b0, 9'h000},
          1'b0, '0},
        '{'{tie_pkg::OP_APPEND, tie_pkg::C_BEQZ, 16'h0063, 16'h0001, 1'b1, 1'b0, 9'h000},
          1'b0, '0},
        '{'{tie_pkg::OP_APPEND, tie_pkg::C_BNEZ, 16'h7fff, 16'h0001, 1'b0, 1'b0, 9'h000},
          1'b0, '0},
        '{'{tie_pkg::OP_APPEND, C_UNUSED, 16'h0003, 16'h0004, 1'b1, 1'b1, 9'h000},
          1'b0, '0},
        '{'{tie_pkg::OP_APPEND, tie_pkg::C_JMP, 16'h7fff, 16'h0000, 1'b0, 1'b0, 9'h000},
          1'b0, '0},
        '{'{tie_pkg::OP_START, tie_pkg::C_MOV, 16'hffff, 16'hffff, 1'b1, 1'b1, 9'h1ff},
          1'b1, '{16'd0, 1'b0, 1'b0, 8'h00, 1'b0, tie_pkg::F_NONE}},
        '{'{tie_pkg::OP_STEP, tie_pkg::C_MOV, 16'h0000, 16'h0000, 1'b0, 1'b0, 9'h1ff},
          1'b0, '0},
        '{'{tie_pkg::OP_STEP, tie_pkg::C_MOV, 16'h0000, 16'h0000, 1'b0, 1'b0, 9'h1ff},
          1'b1, '{16'd2, 1'b0, 1'b0, 8'h00, 1'b0, tie_pkg::F_DIV0}},
        '{'{tie_pkg::OP_STEP, tie_pkg::C_MOV, 16'h0000, 16'h0000, 1'b0, 1'b0, 9'h1ff},
          1'b1, '{16'd3, 1'b0, 1'b1, 8'hff, 1'b0, tie_pkg::F_NONE}},
        '{'{tie_pkg::OP_STEP, tie_pkg::C_MOV, 16'h0000, 16'h0000, 1'b0, 1'b0, 9'h1ff},
          1'b0, '0},
        '{'{tie_pkg::OP_STEP, tie_pkg::C_MOV, 16'h0000, 16'h0000, 1'b0, 1'b0, 9'h0ff},
          1'b0, '0},
        '{'{tie_pkg::OP_STEP, tie_pkg::C_MOV, 16'h0000, 16'h0000, 1'b0, 1'b0, 9'h1ff},
          1'b0, '0},
        '{'{tie_pkg::OP_STEP, tie_pkg::C_MOV, 16'h0000, 16'h0000, 1'b0, 1'b0, 9'h1ff},
          1'b0, '0},
        '{'{tie_pkg::OP_STEP, tie_pkg::C_MOV, 16'h0000, 16'h0000, 1'b0, 1'b0, 9'h1ff},
          1'b0, '0},
        '{'{tie_pkg::OP_STEP, tie_pkg::C_MOV, 16'h0000, 16'h0000, 1'b0, 1'b0, 9'h1ff},
          1'b0, '0},
        '{'{tie_pkg::OP_STEP, tie_pkg::C_MOV, 16'h0000, 16'h0000, 1'b0, 1'b0, 9'h1ff},
          1'b0, '0},
        '{'{tie_pkg::OP_STEP, tie_pkg::C_MOV, 16'h0000, 16'h0000, 1'b0, 1'b0, 9'h1ff},
          1'b0, '0},
        '{'{tie_pkg::OP_CLEAR, tie_pkg::C_MOV, 16'h0000, 16'h0000, 1'b0, 1'b0, 9'h000},
          1'b0, '0}
    };

    initial begin
        t_cmd c;
        int n, target;
        bit filled;
        filled = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (dir_rows[i]) send(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].r);
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin tx_idle = 0;  rx_pct = 0;  end
                1: begin tx_idle = 68; rx_pct = 0;  end
                2: begin tx_idle = 0;  rx_pct = 68; end
                default: begin tx_idle = 6; rx_pct = 6; end
            endcase
            target = sent + ITEMS / 4;
            while (sent < target) begin
                if (ph == 0 && !filled && sent > 150) begin
                    // overfill the program store
                    filled = 1'b1;
                    send('{tie_pkg::OP_CLEAR, 4'($urandom), 16'($urandom), 16'($urandom),
                           1'b0, 1'b0, pick_char()}, 1'b0, '0);
                    for (int i = 0; i < tie_pkg::PROG_DEPTH + 3; i++)
                        send(pick_instr(8), 1'b0, '0);
                end else if ($urandom_range(0, 9) == 0) begin
                    c = {2'($urandom), 4'($urandom), 16'($urandom), 16'($urandom),
                         1'($urandom), 1'($urandom), 9'($urandom)};
                    send(c, 1'b0, '0);
                end else begin
                    n = $urandom_range(1, 8);
                    c = '0;
                    c.op = tie_pkg::OP_CLEAR;
                    send(c, 1'b0, '0);
                    for (int i = 0; i < n; i++) send(pick_instr(n), 1'b0, '0);
                    c.op = tie_pkg::OP_START;
                    send(c, 1'b0, '0);
                    c.op = tie_pkg::OP_STEP;
                    for (int i = 0; i < 2 * n + $urandom_range(0, 4); i++) begin
                        c.ch = pick_char();
                        send(c, 1'b0, '0);
                    end
                end
            end
        end
        i_valid <= 1'b0;
        wait (expected_results.size() == 0);
        repeat (200) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS tiny_interpreter_execute_unit_top");
        end else begin
            $display("FAIL tiny_interpreter_execute_unit_top");
        end
        $finish;
    end
endmodule
`default_nettype wire
